@@ rtl/length_prefixed_datagram_deframer_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefixed datagram deframer
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_DATAGRAM_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_DATAGRAM_DEFRAMER_UNIT_ASSERT_SVH

`ifndef SYNTH
// check a property on every clock edge outside reset
`define LPDD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define LPDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPDD_ASSERT(lbl, clk, rst, prop, msg)
`define LPDD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/lpdd_pkg.sv @@
// ---------------------------------------------------------------------------
// lpdd_pkg
// Types and constants shared by the datagram deframer files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpdd_pkg;

   // default width of the largest accepted part length
   localparam int unsigned MAX_LENGTH_BITS_DEFAULT = 31;

   // beat field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned LEN_W    = 32;

   // command carried by an input beat
   typedef enum logic {
      CMD_BYTE  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   // tag carried by a result beat
   typedef enum logic [STATUS_W-1:0] {
      ST_LENGTH  = 3'd0,
      ST_HEADER  = 3'd1,
      ST_CONTENT = 3'd2,
      ST_TOO_BIG = 3'd3,
      ST_REFUSED = 3'd4,
      ST_CLEARED = 3'd5
   } status_type;

   // parser phase, one-hot
   typedef enum logic [3:0] {
      PH_LENGTHS = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_CONTENT = 4'b0100,
      PH_ERROR   = 4'b1000
   } phase_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [BYTE_W-1:0] stream_byte;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      status_type        status;
      logic              header_done;
      logic              datagram_done;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/lpdd_if.sv @@
// ---------------------------------------------------------------------------
// lpdd_req_if / lpdd_rsp_if
// Valid/ready channels for stream bytes in and tagged bytes out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpdd_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [lpdd_pkg::BYTE_W-1:0]     stream_byte;

   modport source (output valid, output cmd, output stream_byte, input ready);
   modport sink   (input valid, input cmd, input stream_byte, output ready);
endinterface

interface lpdd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lpdd_pkg::BYTE_W-1:0]     out_byte;
   logic [lpdd_pkg::STATUS_W-1:0]   status;
   logic                            header_done;
   logic                            datagram_done;

   modport source (output valid, output out_byte, output status, output header_done,
                   output datagram_done, input ready);
   modport sink   (input valid, input out_byte, input status, input header_done,
                   input datagram_done, output ready);
endinterface

`default_nettype wire

@@ rtl/lpdd_parse.sv @@
// ---------------------------------------------------------------------------
// lpdd_parse
// Parser state and the single-pass step that tags one byte per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefixed_datagram_deframer_unit_assert.svh"

module lpdd_parse #(
   parameter int unsigned MAX_LENGTH_BITS = lpdd_pkg::MAX_LENGTH_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire lpdd_pkg::item_type   item,
   output      lpdd_pkg::result_type result
);

   lpdd_pkg::phase_type              phase_ff, phase_in;
   logic [2:0]                       count_ff, count_in;
   logic [lpdd_pkg::LEN_W-1:0]       hdr_len_ff, hdr_len_in;
   logic [lpdd_pkg::LEN_W-1:0]       cnt_len_ff, cnt_len_in;
   logic [MAX_LENGTH_BITS-1:0]       left_ff, left_in;
   logic [MAX_LENGTH_BITS-1:0]       left_dec;
   logic                             start_content;

   assign left_dec = left_ff - {{(MAX_LENGTH_BITS-1){1'b0}}, 1'b1};

   // work out the tag for this byte and the next parser state
   always_comb begin
      phase_in             = phase_ff;
      count_in             = count_ff;
      hdr_len_in           = hdr_len_ff;
      cnt_len_in           = cnt_len_ff;
      left_in              = left_ff;
      start_content        = 1'b0;
      result.out_byte      = item.stream_byte;
      result.status        = lpdd_pkg::ST_REFUSED;
      result.header_done   = 1'b0;
      result.datagram_done = 1'b0;

      if (item.cmd == lpdd_pkg::CMD_CLEAR) begin
         phase_in        = lpdd_pkg::PH_LENGTHS;
         count_in        = 3'd0;
         hdr_len_in      = '0;
         cnt_len_in      = '0;
         left_in         = '0;
         result.out_byte = '0;
         result.status   = lpdd_pkg::ST_CLEARED;
      end else begin
         case (phase_ff)
            lpdd_pkg::PH_LENGTHS: begin
               result.status = lpdd_pkg::ST_LENGTH;
               if (!count_ff[2]) begin
                  hdr_len_in = {hdr_len_ff[lpdd_pkg::LEN_W-9:0], item.stream_byte};
               end else begin
                  cnt_len_in = {cnt_len_ff[lpdd_pkg::LEN_W-9:0], item.stream_byte};
               end
               count_in = count_ff + 3'd1;
               // eighth length byte: check limits and pick the next part
               if (count_ff == 3'd7) begin
                  if (((hdr_len_in >> MAX_LENGTH_BITS) != '0) ||
                      ((cnt_len_in >> MAX_LENGTH_BITS) != '0)) begin
                     result.status = lpdd_pkg::ST_TOO_BIG;
                     phase_in      = lpdd_pkg::PH_ERROR;
                     left_in       = '0;
                  end else if (hdr_len_in == '0) begin
                     result.header_done = 1'b1;
                     start_content      = 1'b1;
                  end else begin
                     phase_in = lpdd_pkg::PH_HEADER;
                     left_in  = hdr_len_in[MAX_LENGTH_BITS-1:0];
                  end
               end
            end
            lpdd_pkg::PH_HEADER: begin
               result.status = lpdd_pkg::ST_HEADER;
               left_in       = left_dec;
               if (left_dec == '0) begin
                  result.header_done = 1'b1;
                  start_content      = 1'b1;
               end
            end
            lpdd_pkg::PH_CONTENT: begin
               result.status = lpdd_pkg::ST_CONTENT;
               left_in       = left_dec;
               if (left_dec == '0) begin
                  result.datagram_done = 1'b1;
                  phase_in             = lpdd_pkg::PH_LENGTHS;
               end
            end
            default: begin
               result.status = lpdd_pkg::ST_REFUSED;
            end
         endcase

         // enter the content part, or end the datagram when it is empty
         if (start_content) begin
            if (cnt_len_in == '0) begin
               result.datagram_done = 1'b1;
               phase_in             = lpdd_pkg::PH_LENGTHS;
               left_in              = '0;
            end else begin
               phase_in = lpdd_pkg::PH_CONTENT;
               left_in  = cnt_len_in[MAX_LENGTH_BITS-1:0];
            end
         end
      end
   end

   // advance the parser once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lpdd_pkg::PH_LENGTHS;
         count_ff   <= 3'd0;
         hdr_len_ff <= '0;
         cnt_len_ff <= '0;
         left_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         hdr_len_ff <= hdr_len_in;
         cnt_len_ff <= cnt_len_in;
         left_ff    <= left_in;
      end
   end

   `LPDD_ASSERT(a_part_has_bytes_left, clock, reset, (phase_ff == lpdd_pkg::PH_HEADER || phase_ff == lpdd_pkg::PH_CONTENT) |-> (left_ff != '0), "header or content phase with no bytes left")
   `LPDD_ASSERT(a_clear_restarts, clock, reset, (step && item.cmd == lpdd_pkg::CMD_CLEAR) |=> (phase_ff == lpdd_pkg::PH_LENGTHS && count_ff == 3'd0), "clear did not restart the parser")
   `LPDD_ASSERT(a_error_sticky, clock, reset, (step && item.cmd == lpdd_pkg::CMD_BYTE && phase_ff == lpdd_pkg::PH_ERROR) |=> (phase_ff == lpdd_pkg::PH_ERROR), "error phase left without a clear")

endmodule

`default_nettype wire

@@ rtl/length_prefixed_datagram_deframer_unit.sv @@
// ---------------------------------------------------------------------------
// length_prefixed_datagram_deframer_unit
// Splits a byte stream into length-prefixed datagrams and tags every byte.
// ---------------------------------------------------------------------------
// Takes one beat per clock while results are taken and returns one tagged
// beat for each, in order. A beat passes an input register, the single-pass
// parse step and a result register, from which it is offered. The rate is
// one beat per cycle while the receiver keeps up, set by the parse step that
// updates the length counters and the phase for every beat. The input side
// keeps taking beats while a result waits, until both registers hold an
// untaken beat. Each datagram opens with a big-endian 32-bit header length
// and a 32-bit content length; a length above 2^MAX_LENGTH_BITS-1 sends the
// parser into an error state that refuses bytes until a clear command. No
// clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefixed_datagram_deframer_unit_assert.svh"

module length_prefixed_datagram_deframer_unit #(
   parameter int unsigned MAX_LENGTH_BITS = lpdd_pkg::MAX_LENGTH_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   lpdd_req_if.sink   req_chan,
   lpdd_rsp_if.source rsp_chan
);

   logic                 in_valid_ff;
   lpdd_pkg::item_type   in_item_ff;
   logic                 out_valid_ff;
   lpdd_pkg::result_type out_result_ff;
   lpdd_pkg::result_type step_result;
   logic                 out_free;
   logic                 advance;
   logic                 req_accept;

   // move a beat on when the result register is empty or being emptied
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign advance    = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   // hold the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.cmd         <= lpdd_pkg::cmd_type'(req_chan.cmd);
         in_item_ff.stream_byte <= req_chan.stream_byte;
      end
   end

   lpdd_parse #(
      .MAX_LENGTH_BITS (MAX_LENGTH_BITS)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (step_result)
   );

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.out_byte      = out_result_ff.out_byte;
   assign rsp_chan.status        = out_result_ff.status;
   assign rsp_chan.header_done   = out_result_ff.header_done;
   assign rsp_chan.datagram_done = out_result_ff.datagram_done;

   `LPDD_ASSERT(a_advance_loads_result, clock, reset, advance |=> out_valid_ff, "parsed beat not loaded into result register")
   `LPDD_ASSERT(a_blocked_beat_held, clock, reset, (in_valid_ff && !out_free) |=> in_valid_ff, "input beat dropped while result register blocked")
   `LPDD_ASSERT(a_header_done_tag, clock, reset, (out_valid_ff && out_result_ff.header_done) |-> (out_result_ff.status == lpdd_pkg::ST_LENGTH || out_result_ff.status == lpdd_pkg::ST_HEADER), "header end flagged on a byte outside lengths or header")
   `LPDD_ASSERT_ALWAYS(a_no_flags_on_fault, clock, (out_valid_ff && (out_result_ff.status == lpdd_pkg::ST_TOO_BIG || out_result_ff.status == lpdd_pkg::ST_REFUSED || out_result_ff.status == lpdd_pkg::ST_CLEARED)) |-> (!out_result_ff.header_done && !out_result_ff.datagram_done), "done flag on an error or clear result")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: length-prefixed datagram deframer testbench
// Drives a byte stream with clear commands through the request channel and
// checks each tagged result beat against an in-bench parser model. The
// stimulus starts with a few directed datagrams and then runs random
// datagrams, oversized and cut-short frames, noise and clears. Both channels
// idle at random, and one long receiver hold-off backs the block up.
// ---------------------------------------------------------------------------
module tb;
   import lpdd_pkg::*;

   // largest legal part length for the default build
   localparam logic [LEN_W-1:0] LEN_LIMIT = 32'((64'd1 << MAX_LENGTH_BITS_DEFAULT) - 64'd1);
   localparam int STREAM_BEATS = 1380;
   localparam int DRAIN_EVERY  = 260;
   localparam int HOLD_OFF_AT  = 400;

   typedef struct {
      item_type beat;
      bit       drain_first;
   } stream_beat_type;

   logic clock;
   logic reset;

   lpdd_req_if req_chan ();
   lpdd_rsp_if rsp_chan ();

   length_prefixed_datagram_deframer_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // stream beats still to send and tagged beats still to arrive
   stream_beat_type pending_beats[$];
   result_type      expected_tags[$];

   // parser model state
   phase_type          parse_phase;
   logic [2:0]         len_bytes_seen;
   logic [LEN_W-1:0]   hdr_len;
   logic [LEN_W-1:0]   body_len;
   logic [30:0]        bytes_due;

   int  failures;
   int  beats_taken;
   int  datagrams_seen;
   int  too_big_seen;
   int  refused_seen;
   int  clears_seen;
   bit  req_taken;
   bit  drain_next;
   int  burst_left;
   int  gap_left;
   int  hold_off_left;
   bit  hold_off_done;
   int  pattern_age;
   logic [15:0] ready_pattern;

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   function automatic void clear_parser();
      parse_phase    = PH_LENGTHS;
      len_bytes_seen = '0;
      hdr_len        = '0;
      body_len       = '0;
      bytes_due      = '0;
   endfunction

   // header finished: start the content, or close the datagram if it is empty
   function automatic void enter_content(inout result_type tag);
      if (body_len == '0) begin
         tag.datagram_done = 1'b1;
         parse_phase       = PH_LENGTHS;
         bytes_due         = '0;
      end else begin
         parse_phase = PH_CONTENT;
         bytes_due   = body_len[30:0];
      end
   endfunction

   function automatic result_type deframe_byte(item_type it);
      result_type tag;
      tag.out_byte      = it.stream_byte;
      tag.status        = ST_LENGTH;
      tag.header_done   = 1'b0;
      tag.datagram_done = 1'b0;
      if (it.cmd == CMD_CLEAR) begin
         clear_parser();
         tag.out_byte = '0;
         tag.status   = ST_CLEARED;
      end else begin
         case (parse_phase)
            PH_LENGTHS: begin
               if (len_bytes_seen < 3'd4)
                  hdr_len = {hdr_len[LEN_W-9:0], it.stream_byte};
               else
                  body_len = {body_len[LEN_W-9:0], it.stream_byte};
               len_bytes_seen = len_bytes_seen + 3'd1;
               if (len_bytes_seen == 3'd0) begin
                  if (hdr_len > LEN_LIMIT || body_len > LEN_LIMIT) begin
                     tag.status  = ST_TOO_BIG;
                     parse_phase = PH_ERROR;
                     bytes_due   = '0;
                  end else if (hdr_len == '0) begin
                     tag.header_done = 1'b1;
                     enter_content(tag);
                  end else begin
                     parse_phase = PH_HEADER;
                     bytes_due   = hdr_len[30:0];
                  end
               end
            end
            PH_HEADER: begin
               tag.status = ST_HEADER;
               bytes_due  = bytes_due - 31'd1;
               if (bytes_due == '0) begin
                  tag.header_done = 1'b1;
                  enter_content(tag);
               end
            end
            PH_CONTENT: begin
               tag.status = ST_CONTENT;
               bytes_due  = bytes_due - 31'd1;
               if (bytes_due == '0) begin
                  tag.datagram_done = 1'b1;
                  parse_phase       = PH_LENGTHS;
               end
            end
            default: begin
               tag.status = ST_REFUSED;
            end
         endcase
      end
      return tag;
   endfunction

   // ------------------------------------------------------------------------
   // Stream building
   // ------------------------------------------------------------------------
   function automatic void add_beat(cmd_type c, logic [BYTE_W-1:0] b);
      stream_beat_type sb;
      sb.beat.cmd         = c;
      sb.beat.stream_byte = b;
      sb.drain_first      = drain_next;
      drain_next          = 1'b0;
      pending_beats.push_back(sb);
   endfunction

   function automatic void add_random_bytes(int count);
      for (int i = 0; i < count; i++)
         add_beat(CMD_BYTE, 8'($urandom));
   endfunction

   // big-endian header length, then content length
   function automatic void add_lengths(logic [LEN_W-1:0] hl, logic [LEN_W-1:0] cl);
      for (int i = 3; i >= 0; i--)
         add_beat(CMD_BYTE, hl[i*8 +: 8]);
      for (int i = 3; i >= 0; i--)
         add_beat(CMD_BYTE, cl[i*8 +: 8]);
   endfunction

   function automatic logic [LEN_W-1:0] short_length(int longest);
      if ($urandom_range(0, 3) == 0)
         return '0;
      return LEN_W'($urandom_range(1, longest));
   endfunction

   // legal length with many high bits set
   function automatic logic [LEN_W-1:0] long_length();
      logic [LEN_W-1:0] len;
      len = $urandom & LEN_LIMIT;
      if ($urandom_range(0, 3) == 0 || len == '0)
         len = LEN_LIMIT;
      return len;
   endfunction

   function automatic logic [LEN_W-1:0] oversized_length();
      case ($urandom_range(0, 3))
         0:       return 32'h8000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom | 32'h8000_0000;
      endcase
   endfunction

   function automatic void add_random_episode();
      logic [LEN_W-1:0] hl;
      logic [LEN_W-1:0] cl;
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
         // well-formed datagram, random content
         hl = short_length(6);
         cl = short_length(10);
         add_lengths(hl, cl);
         add_random_bytes(int'(hl) + int'(cl));
      end else if (pick < 76) begin
         // legal but long part, abandoned by a clear
         if ($urandom_range(0, 1) == 0) begin
            add_lengths(long_length(), short_length(4));
            add_random_bytes($urandom_range(0, 5));
         end else begin
            hl = short_length(2);
            add_lengths(hl, long_length());
            add_random_bytes(int'(hl) + $urandom_range(0, 5));
         end
         add_beat(CMD_CLEAR, 8'($urandom));
      end else if (pick < 84) begin
         // oversized length, refused bytes, then recover
         sel = $urandom_range(1, 3);
         hl  = sel[0] ? oversized_length() : short_length(6);
         cl  = sel[1] ? oversized_length() : short_length(6);
         add_lengths(hl, cl);
         add_random_bytes($urandom_range(0, 4));
         add_beat(CMD_CLEAR, 8'($urandom));
      end else if (pick < 92) begin
         // frame cut short by a clear
         if ($urandom_range(0, 1) == 0) begin
            add_random_bytes($urandom_range(1, 7));
         end else begin
            hl = LEN_W'($urandom_range(2, 6));
            cl = LEN_W'($urandom_range(1, 6));
            add_lengths(hl, cl);
            add_random_bytes($urandom_range(1, int'(hl) + int'(cl) - 1));
         end
         add_beat(CMD_CLEAR, 8'($urandom));
      end else if (pick < 97) begin
         // noise with stray clears, then resynchronise
         for (int i = $urandom_range(1, 6); i > 0; i--)
            add_beat(cmd_type'($urandom_range(0, 1)), 8'($urandom));
         add_beat(CMD_CLEAR, 8'($urandom));
      end else begin
         add_beat(CMD_CLEAR, 8'($urandom));
      end
   endfunction

   // ------------------------------------------------------------------------
   // Clock and initial pin state
   // ------------------------------------------------------------------------
   initial begin
      clock                = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.cmd         = 1'b0;
      req_chan.stream_byte = '0;
      rsp_chan.ready       = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------------
   initial begin
      int next_drain;
      failures       = 0;
      beats_taken    = 0;
      datagrams_seen = 0;
      too_big_seen   = 0;
      refused_seen   = 0;
      clears_seen    = 0;
      drain_next     = 1'b0;
      burst_left     = 1;
      gap_left       = 0;
      hold_off_left  = 0;
      hold_off_done  = 1'b0;
      pattern_age    = 0;
      ready_pattern  = '1;
      reset          = 1'b1;
      clear_parser();

      // empty header and empty content: both flags on the last length byte
      add_lengths('0, '0);
      // one header byte, no content: the header byte ends the datagram
      add_lengths(32'd1, '0);
      add_beat(CMD_BYTE, 8'hFF);
      // oversized header length, one refused byte, then clear
      add_lengths(32'h8000_0000, '0);
      add_beat(CMD_BYTE, 8'h00);
      add_beat(CMD_CLEAR, 8'hA5);

      // random part, pausing for a full drain now and then
      drain_next = 1'b1;
      next_drain = pending_beats.size() + DRAIN_EVERY;
      while (pending_beats.size() < STREAM_BEATS) begin
         if (pending_beats.size() >= next_drain) begin
            drain_next = 1'b1;
            next_drain += DRAIN_EVERY;
         end
         add_random_episode();
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || expected_tags.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("tb: %0d beats taken, %0d datagrams closed, %0d oversized lengths",
               beats_taken, datagrams_seen, too_big_seen);
      $display("tb: %0d bytes refused in error, %0d clears, one long receiver hold-off",
               refused_seen, clears_seen);
      if (failures == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // give up on a hung run
   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sender: bursts of beats with random gaps
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         // retire the beat taken at the last edge
         if (req_taken) begin
            pending_beats.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (req_chan.valid && !req_taken) begin
            // hold the beat until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_beats.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (pending_beats[0].drain_first && expected_tags.size() != 0) begin
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid       <= 1'b1;
            req_chan.cmd         <= pending_beats[0].beat.cmd;
            req_chan.stream_byte <= pending_beats[0].beat.stream_byte;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: rotating stall pattern plus one long hold-off
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!hold_off_done && beats_taken >= HOLD_OFF_AT) begin
         hold_off_done  = 1'b1;
         hold_off_left  = 199;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            pattern_age   = $urandom_range(16, 80);
         end
         pattern_age--;
         rsp_chan.ready <= ready_pattern[0];
         ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on each input beat, check each result beat
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      item_type   it;
      result_type got;
      result_type want;
      if (reset) begin
         clear_parser();
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            it.cmd         = cmd_type'(req_chan.cmd);
            it.stream_byte = req_chan.stream_byte;
            expected_tags.push_back(deframe_byte(it));
            beats_taken++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.out_byte      = rsp_chan.out_byte;
            got.status        = status_type'(rsp_chan.status);
            got.header_done   = rsp_chan.header_done;
            got.datagram_done = rsp_chan.datagram_done;
            if (expected_tags.size() == 0) begin
               failures++;
               $display("%0t: unexpected result beat, byte %0h status %0d flags %b%b",
                        $realtime, got.out_byte, got.status, got.header_done,
                        got.datagram_done);
            end else begin
               want = expected_tags.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  failures++;
                  $display("%0t: out_byte expected %0h actual %0h",
                           $realtime, want.out_byte, got.out_byte);
               end
               if (got.status !== want.status) begin
                  failures++;
                  $display("%0t: status expected %0d actual %0d",
                           $realtime, want.status, got.status);
               end
               if (got.header_done !== want.header_done) begin
                  failures++;
                  $display("%0t: header_done expected %b actual %b",
                           $realtime, want.header_done, got.header_done);
               end
               if (got.datagram_done !== want.datagram_done) begin
                  failures++;
                  $display("%0t: datagram_done expected %b actual %b",
                           $realtime, want.datagram_done, got.datagram_done);
               end
               // tally what the run went through
               if (want.datagram_done)
                  datagrams_seen++;
               case (want.status)
                  ST_TOO_BIG: too_big_seen++;
                  ST_REFUSED: refused_seen++;
                  ST_CLEARED: clears_seen++;
                  default: begin
                  end
               endcase
            end
         end
      end
   end

endmodule
